>>> hw/rtl/u8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

  localparam int unsigned CpW = 21;
  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // Byte classes, set once at the input side
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } cls_e;

  // One classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_e       cls;
  } tok_t;

  // Back-end sequencer states
  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } st_e;

endpackage

>>> hw/rtl/u8d_front.sv
// Front end: classifies incoming bytes and queues them for the back end.
module u8d_front import u8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       string_end_i,
  output logic       tok_valid_o,
  output tok_t       tok_o,
  input  logic       tok_pop_i
);

  tok_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  tok_t       tok_new;

  // Classify the byte by its lead pattern
  always_comb begin
    tok_new.data = byte_in_i;
    tok_new.last = string_end_i;
    if (byte_in_i inside {[8'h00:8'h7F]}) begin
      tok_new.cls = CLS_ASCII;
    end else if (byte_in_i inside {[8'h80:8'hBF]}) begin
      tok_new.cls = CLS_CONT;
    end else if (byte_in_i inside {[8'hC0:8'hDF]}) begin
      tok_new.cls = CLS_LEAD2;
    end else if (byte_in_i inside {[8'hE0:8'hEF]}) begin
      tok_new.cls = CLS_LEAD3;
    end else if (byte_in_i inside {[8'hF0:8'hF7]}) begin
      tok_new.cls = CLS_LEAD4;
    end else begin
      tok_new.cls = CLS_BAD;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_o       = q_mem[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified request
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= tok_new;
    end
  end

endmodule

>>> hw/rtl/u8d_back.sv
// Back end: holds pending bytes, emits one code point per cycle while resolving and the output is not stalled.
module u8d_back import u8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tok_valid_i,
  input  tok_t           tok_i,
  output logic           tok_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] code_point_o,
  output logic           final_of_string_o,
  output logic           final_of_run_o
);

  st_e            state_q, state_d;
  logic [7:0]     buf_q [4];
  cls_e           cls_q [4];
  logic [7:0]     buf_d [4];
  cls_e           cls_d [4];
  logic [2:0]     cnt_q, cnt_d;
  logic           last_q, last_d;
  logic           out_valid_q;
  logic [CpW-1:0] code_q;
  logic           fos_q, for_q;

  logic           lead_ok;
  logic [1:0]     extra;
  logic           short_seq;
  logic           cont_bad;
  logic           emit;
  logic [CpW-1:0] emit_cp;
  logic [2:0]     shift;
  logic [2:0]     cnt_left;
  logic [2:0]     src;
  logic           nxt_lead_ok;
  logic [1:0]     nxt_extra;
  logic           more;
  logic           slot_free;
  logic           stall;
  logic           run_done;

  assign slot_free = !out_valid_q || out_ready_i;

  // Decode the byte at the head of the buffer
  always_comb begin
    lead_ok = 1'b1;
    extra   = 2'd0;
    case (cls_q[0])
      CLS_ASCII: extra = 2'd0;
      CLS_LEAD2: extra = 2'd1;
      CLS_LEAD3: extra = 2'd2;
      CLS_LEAD4: extra = 2'd3;
      default:   lead_ok = 1'b0;
    endcase
    short_seq = ({1'b0, extra} >= cnt_q);
    cont_bad  = ((extra >= 2'd1) && (cls_q[1] != CLS_CONT))
             || ((extra >= 2'd2) && (cls_q[2] != CLS_CONT))
             || ((extra == 2'd3) && (cls_q[3] != CLS_CONT));
    case (cls_q[0])
      CLS_LEAD2: emit_cp = CpW'({buf_q[0][4:0], buf_q[1][5:0]});
      CLS_LEAD3: emit_cp = CpW'({buf_q[0][3:0], buf_q[1][5:0], buf_q[2][5:0]});
      CLS_LEAD4: emit_cp = {buf_q[0][2:0], buf_q[1][5:0], buf_q[2][5:0],
                            buf_q[3][5:0]};
      default:   emit_cp = CpW'(buf_q[0]);
    endcase
  end

  // Choose the step outcome: whether a result goes out and how many bytes it uses up
  always_comb begin
    emit  = 1'b0;
    shift = 3'd0;
    if (state_q == ST_RUN) begin
      if (!lead_ok) begin
        emit  = 1'b1;
        shift = 3'd1;
      end else if (short_seq) begin
        emit = last_q;
        if (last_q) begin
          shift = cnt_q;
        end
      end else if (cont_bad) begin
        emit  = 1'b1;
        shift = 3'd1;
      end else begin
        emit  = 1'b1;
        shift = {1'b0, extra} + 3'd1;
      end
    end
    cnt_left = cnt_q - shift;
  end

  // Shift the buffer down past the used bytes, or append a loaded byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      buf_d[i] = buf_q[i];
      cls_d[i] = cls_q[i];
    end
    src = 3'd0;
    if (state_q == ST_LOAD) begin
      buf_d[cnt_q[1:0]] = tok_i.data;
      cls_d[cnt_q[1:0]] = tok_i.cls;
    end else begin
      for (int i = 0; i < 4; i++) begin
        src = 3'(i) + shift;
        if (src < 3'd4) begin
          buf_d[i] = buf_q[src[1:0]];
          cls_d[i] = cls_q[src[1:0]];
        end
      end
    end
  end

  // Look ahead: does the remaining buffer give another result this run
  always_comb begin
    nxt_lead_ok = 1'b1;
    nxt_extra   = 2'd0;
    case (cls_d[0])
      CLS_ASCII: nxt_extra = 2'd0;
      CLS_LEAD2: nxt_extra = 2'd1;
      CLS_LEAD3: nxt_extra = 2'd2;
      CLS_LEAD4: nxt_extra = 2'd3;
      default:   nxt_lead_ok = 1'b0;
    endcase
    more = (cnt_left != 3'd0)
        && !(nxt_lead_ok && ({1'b0, nxt_extra} >= cnt_left) && !last_q);
  end

  assign stall    = emit && !slot_free;
  assign run_done = !emit || !more;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (tok_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stall && run_done) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs and register updates of the sequencer
  always_comb begin
    tok_pop_o = (state_q == ST_LOAD) && tok_valid_i;
    cnt_d     = cnt_q;
    last_d    = last_q;
    if (tok_pop_o) begin
      cnt_d  = cnt_q + 3'd1;
      last_d = tok_i.last;
    end else if ((state_q == ST_RUN) && !stall) begin
      cnt_d = cnt_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= 3'd0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      if (emit && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold bytes and the result payload
  always_ff @(posedge clk_i) begin
    if (tok_pop_o || ((state_q == ST_RUN) && !stall)) begin
      for (int i = 0; i < 4; i++) begin
        buf_q[i] <= buf_d[i];
        cls_q[i] <= cls_d[i];
      end
    end
    if (emit && slot_free) begin
      code_q <= (!lead_ok || short_seq || cont_bad) ? Replacement : emit_cp;
      for_q  <= !more;
      fos_q  <= !more && last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign code_point_o      = code_q;
  assign final_of_string_o = fos_q;
  assign final_of_run_o    = for_q;

endmodule

>>> hw/rtl/utf8_stream_decoder.sv
// A request is stored in the front-end queue, loaded into the back-end buffer, then
// resolved into the output register; each further result of the same byte takes another
// resolve step, and output stalls hold it. The back-end sequencer loads a byte, then
// resolves one code point per cycle unless the output stalls, and takes no new byte
// until its run is done; the front-end queue holds waiting bytes meanwhile.
// Reset clears the queue, the held-byte count and the output valid flag.
module utf8_stream_decoder import u8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     byte_in_i,
  input  logic           string_end_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] code_point_o,
  output logic           final_of_string_o,
  output logic           final_of_run_o
);

  logic tok_valid;
  tok_t tok;
  logic tok_pop;

  u8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .string_end_i (string_end_i),
    .tok_valid_o  (tok_valid),
    .tok_o        (tok),
    .tok_pop_i    (tok_pop)
  );

  u8d_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tok_valid_i       (tok_valid),
    .tok_i             (tok),
    .tok_pop_o         (tok_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .code_point_o      (code_point_o),
    .final_of_string_o (final_of_string_o),
    .final_of_run_o    (final_of_run_o)
  );

endmodule

>>> hw/rtl/u8d_checker.sv
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
module u8d_checker import u8d_pkg::*; (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input logic [CpW-1:0] code_point_o,
  input logic           final_of_string_o,
  input logic           final_of_run_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o)
      && $stable(final_of_string_o) && $stable(final_of_run_o))
    else $error("stalled result changed");

  // End of string always closes the run of its byte
  a_fos_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_of_string_o |-> final_of_run_o)
    else $error("final_of_string without final_of_run");

  // No result right after reset is released
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

  // Queue accepts as soon as reset is released
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_o)
    else $error("input not ready after reset");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .code_point_o      (code_point_o),
  .final_of_string_o (final_of_string_o),
  .final_of_run_o    (final_of_run_o)
);

>>> dv/testbench.sv
// Self-checking testbench of the UTF-8 stream decoder: byte stimulus and code point scoreboard.
`timescale 1ns / 1ps

import u8d_pkg::*;

typedef logic [7:0] byte_seq_t[$];

// One expected code point with its two flags
typedef struct {
  logic [CpW-1:0] cp;
  logic           eos;
  logic           eor;
} code_point_t;

class utf8_scoreboard;
  logic [7:0]  held_q[3];
  int unsigned held_n;
  code_point_t expected_cps[$];
  int unsigned mismatches;
  int unsigned bytes_seen;
  int unsigned cps_seen;
  int unsigned replacements;
  int unsigned flush_of_four;

  function void clear();
    held_n = 0;
    expected_cps.delete();
  endfunction

  // Decode one accepted byte against the held bytes and queue what it releases
  function void decode_byte(logic [7:0] data, logic eos);
    logic [7:0]     seq[4];
    logic [7:0]     lead;
    logic [CpW-1:0] cp;
    logic [CpW-1:0] step_q[$];
    code_point_t    res;
    int unsigned    n, s, extra, i;
    logic           ok;
    bytes_seen++;
    for (i = 0; i < held_n; i++) seq[i] = held_q[i];
    seq[held_n] = data;
    n = held_n + 1;
    s = 0;
    while (s < n) begin
      lead = seq[s];
      ok = 1'b1;
      extra = 0;
      cp = '0;
      if (lead < 8'h80) begin
        cp = CpW'(lead);
      end else if ((lead & 8'hE0) == 8'hC0) begin
        cp = CpW'(lead & 8'h1F);
        extra = 1;
      end else if ((lead & 8'hF0) == 8'hE0) begin
        cp = CpW'(lead & 8'h0F);
        extra = 2;
      end else if ((lead & 8'hF8) == 8'hF0) begin
        cp = CpW'(lead & 8'h07);
        extra = 3;
      end else begin
        // Invalid lead: replace and drop just this byte
        step_q = {step_q, Replacement};
        s++;
        continue;
      end
      // Incomplete sequence: hold, or replace and swallow at end of string
      if (s + extra >= n) begin
        if (eos) begin
          step_q = {step_q, Replacement};
          s = n;
        end
        break;
      end
      for (i = 1; i <= extra; i++) begin
        if (seq[s+i][7:6] != 2'b10) begin
          ok = 1'b0;
          break;
        end
        cp = (cp << 6) | CpW'(seq[s+i][5:0]);
      end
      if (ok) begin
        step_q = {step_q, cp};
        s += extra + 1;
      end else begin
        // Bad continuation: drop only the lead and rescan the rest
        step_q = {step_q, Replacement};
        s++;
      end
    end
    held_n = n - s;
    for (i = 0; i < held_n; i++) held_q[i] = seq[s+i];
    if (step_q.size() == 4) flush_of_four++;
    foreach (step_q[j]) begin
      res.cp  = step_q[j];
      res.eor = (j == step_q.size() - 1);
      res.eos = res.eor && eos;
      if (res.cp == Replacement) replacements++;
      expected_cps = {expected_cps, res};
    end
  endfunction

  function void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Compare one accepted code point with the oldest expectation
  function void check_code_point(logic [CpW-1:0] cp, logic eos, logic eor);
    code_point_t want;
    cps_seen++;
    if (expected_cps.size() == 0) begin
      report_mismatch($sformatf("unexpected code point %06h eos=%0b eor=%0b", cp, eos, eor));
      return;
    end
    want = expected_cps.pop_front();
    if (cp !== want.cp || eos !== want.eos || eor !== want.eor) begin
      report_mismatch($sformatf("expected %06h eos=%0b eor=%0b, got %06h eos=%0b eor=%0b",
                                want.cp, want.eos, want.eor, cp, eos, eor));
    end
  endfunction
endclass

module testbench;

  localparam int unsigned RandomBytes   = 460;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned DrainCycles   = 30;

  // Kinds of damage put into random strings
  typedef enum int {
    DMG_BAD_LEAD,
    DMG_BAD_CONT,
    DMG_TRUNCATE,
    DMG_ANY_BYTE
  } damage_e;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  logic [7:0]     byte_in_i;
  logic           string_end_i;
  logic           out_valid_o;
  logic           out_ready_i;
  logic [CpW-1:0] code_point_o;
  logic           final_of_string_o;
  logic           final_of_run_o;

  utf8_scoreboard sb;
  bit             hold_off_req;
  bit             no_idle;
  int unsigned    strings_sent;
  int unsigned    hold_offs_done;

  utf8_stream_decoder i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_in_i        (byte_in_i),
    .string_end_i     (string_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_point_o     (code_point_o),
    .final_of_string_o(final_of_string_o),
    .final_of_run_o   (final_of_run_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_byte(input logic [7:0] data, input logic eos);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_in_i    <= data;
    string_end_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    sb.decode_byte(data, eos);
  endtask

  task automatic send_string(input byte_seq_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    strings_sent++;
  endtask

  // Build a string of well-formed sequences with random payload and some damage
  task automatic build_random_string(output byte_seq_t bytes);
    int unsigned n_cp, r, len;
    logic [7:0]  seq[4];
    logic [1:0]  top;
    damage_e     dmg;
    bytes.delete();
    n_cp = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
    for (int c = 0; c < n_cp; c++) begin
      r = $urandom_range(0, 99);
      len = (r < 30) ? 1 : (r < 52) ? 2 : (r < 72) ? 3 : 4;
      case (len)
        1: seq[0] = 8'($urandom_range(0, 127));
        2: seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
        3: seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
        default: seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      for (int k = 1; k < len; k++) seq[k] = 8'h80 | 8'($urandom_range(0, 63));
      if ($urandom_range(0, 99) < 18) begin
        dmg = damage_e'($urandom_range(0, 3));
        case (dmg)
          DMG_BAD_LEAD: begin
            seq[0] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                          : 8'($urandom_range(8'hF8, 8'hFF));
          end
          DMG_BAD_CONT: begin
            if (len > 1) begin
              top = 2'($urandom_range(0, 2));
              if (top == 2'b10) top = 2'b11;
              seq[$urandom_range(1, len - 1)] = {top, 6'($urandom_range(0, 63))};
            end
          end
          DMG_TRUNCATE: begin
            // Cut the sequence short and end the string on it
            if (len > 1) begin
              for (int k = 0; k < $urandom_range(1, len - 1); k++) bytes = {bytes, seq[k]};
              return;
            end
          end
          default: seq[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
        endcase
      end
      for (int k = 0; k < len; k++) bytes = {bytes, seq[k]};
    end
  endtask

  // Accept code points and check each one
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      sb.check_code_point(code_point_o, final_of_string_o, final_of_run_o);
    end
  end

  // Drive the receiver: bursts, random stalls and one long hold-off
  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_offs_done++;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        gap = idle_cycles();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("Timeout with %0d code points still expected", sb.expected_cps.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    byte_seq_t   str;
    int unsigned random_start;
    sb = new();
    sb.clear();
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    byte_in_i    <= 8'h00;
    string_end_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ASCII extremes, each sequence length, top code point,
    // invalid leads, bad continuation flushing four results,
    // truncation that hides a bad continuation, lone leads at end of string
    send_string('{8'h00, 8'h7F});
    send_string('{8'hC2, 8'hA9});
    send_string('{8'hE2, 8'h82, 8'hAC});
    send_string('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
    send_string('{8'h80, 8'hFF});
    send_string('{8'hF0, 8'h41, 8'h42, 8'h43});
    send_string('{8'hE2, 8'h41});
    send_string('{8'hF8});
    send_string('{8'hE2, 8'h82});
    send_string('{8'hC2});

    // Random strings; stall the receiver for a long stretch early on
    hold_off_req = 1'b1;
    random_start = sb.bytes_seen;
    while (sb.bytes_seen - random_start < RandomBytes) begin
      no_idle = (strings_sent % 8 == 0);
      build_random_string(str);
      send_string(str);
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    // Drain
    while (sb.expected_cps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Decoded %0d strings, %0d bytes into %0d code points", strings_sent,
             sb.bytes_seen, sb.cps_seen);
    $display("Replacements: %0d, four-result flushes: %0d, long hold-offs: %0d",
             sb.replacements, sb.flush_of_four, hold_offs_done);
    if (sb.expected_cps.size() != 0) begin
      $display("%0d code points never arrived", sb.expected_cps.size());
    end
    if (sb.mismatches == 0 && sb.expected_cps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
